>>> rtl/congestion_window_controller_core_defines.svh
// Assertion macros shared by the congestion window controller.
`ifndef CONGESTION_WINDOW_CONTROLLER_CORE_DEFINES_SVH
`define CONGESTION_WINDOW_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define CWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwc check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define CWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwc check failed");

`endif

>>> rtl/cwc_pkg.sv
package cwc_pkg;

	localparam int unsigned WIN_W = 16;
	localparam int unsigned CNT_W = 4;
	// Window ceiling; any value from 255 up to 65535 works.
	localparam logic [WIN_W-1:0] WIN_MAX = 16'hFFFF;
	localparam logic [WIN_W-1:0] WIN_RESET = 16'd1;
	localparam logic [WIN_W-1:0] THRESH_RESET = 16'd2000;
	localparam logic [CNT_W-1:0] DUP_TRIGGER = 4'd3;
	localparam int unsigned WIDE_W = WIN_W + 3;

	typedef enum logic [1:0] {
		PH_SS = 2'd0,
		PH_CA = 2'd1,
		PH_FR = 2'd2
	} phase_t;

	typedef struct packed {
		logic             timeout_event;
		logic             dup_event;
		logic [CNT_W-1:0] dup_count;
	} cwc_event_t;

	typedef struct packed {
		phase_t           phase;
		logic [WIN_W-1:0] window;
		logic [WIN_W-1:0] threshold;
	} cwc_state_t;

	function automatic logic [WIN_W-1:0] win_sat(input logic [WIDE_W-1:0] v);
		logic [WIN_W-1:0] r;
		if (v > {3'b000, WIN_MAX}) begin
			r = WIN_MAX;
		end else begin
			r = v[WIN_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [WIN_W-1:0] half_plus3(input logic [WIN_W-1:0] v);
		return {1'b0, v[WIN_W-1:1]} + 16'd3;
	endfunction

endpackage

>>> rtl/congestion_window_controller_core.sv
// Congestion window controller: each event transfer (timeout flag, duplicate
// flag, duplicate-ACK count) updates the phase, window and slow-start
// threshold and returns one result carrying the new values plus a request to
// clear the duplicate counter. An event is captured in an input register and
// applied when the state and result registers load together, which waits
// while the result register is full and stalled; the result is presented
// from those registers. One event can be taken every cycle while the output
// side keeps up, since the state update is a single pass of adds and
// compares. After reset the window is 1, the threshold 2000 and the phase
// slow start.
`include "congestion_window_controller_core_defines.svh"

module congestion_window_controller_core import cwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             timeout_event,
	input  logic             dup_event,
	input  logic [CNT_W-1:0] dup_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIN_W-1:0] window,
	output logic [WIN_W-1:0] threshold,
	output logic [1:0]       phase,
	output logic             clear_dup
);

	logic       valid_s1;
	cwc_event_t event_s1;
	cwc_state_t state_q;
	cwc_state_t state_nxt;
	logic       clr_nxt;
	logic       clear_dup_q;
	logic       out_valid_q;
	logic       advance;

	// An event is waiting and the result register is free or being emptied this cycle.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			event_s1.timeout_event <= timeout_event;
			event_s1.dup_event <= dup_event;
			event_s1.dup_count <= dup_count;
		end
	end

	cwc_next u_next (
		.cur (state_q),
		.ev  (event_s1),
		.nxt (state_nxt),
		.clr (clr_nxt)
	);

	// The state registers double as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_SS;
			state_q.window <= WIN_RESET;
			state_q.threshold <= THRESH_RESET;
			clear_dup_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				clear_dup_q <= clr_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign window = state_q.window;
	assign threshold = state_q.threshold;
	assign phase = state_q.phase;
	assign clear_dup = clear_dup_q;

	`CWC_ASSERT_IMP(a_window_nonzero, 1'b1, state_q.window != 16'd0)
	`CWC_ASSERT_IMP(a_no_clear_in_fr, out_valid_q && clear_dup_q, state_q.phase != PH_FR)
	`CWC_ASSERT_NXT(a_advance_fills, advance, out_valid_q)
	`CWC_ASSERT_NXT(a_state_holds, !advance, $stable(state_q))

endmodule

>>> rtl/cwc_next.sv
module cwc_next import cwc_pkg::*; (
	input  cwc_state_t cur,
	input  cwc_event_t ev,
	output cwc_state_t nxt,
	output logic       clr
);

	logic [WIN_W-1:0] w;
	logic [WIN_W-1:0] t;
	logic [WIN_W-1:0] ca_thr;

	assign w = cur.window;
	assign t = cur.threshold;
	assign ca_thr = half_plus3(w);

	always_comb begin
		nxt = cur;
		clr = 1'b0;
		case (cur.phase)
			PH_SS: begin
				if (ev.dup_count == DUP_TRIGGER) begin
					nxt.threshold = half_plus3(t);
					nxt.window = win_sat({3'b000, w} + 19'd5);
					nxt.phase = PH_FR;
				end else if (!ev.timeout_event) begin
					nxt.window = win_sat({w, 3'b000});
					clr = 1'b1;
					if (win_sat({w, 3'b000}) >= t) begin
						nxt.phase = PH_CA;
					end
				end else begin
					nxt.threshold = ca_thr;
					nxt.window = WIN_RESET;
					clr = 1'b1;
				end
			end
			PH_CA: begin
				if (ev.timeout_event) begin
					nxt.threshold = ca_thr;
					nxt.window = WIN_RESET;
					clr = 1'b1;
					nxt.phase = PH_SS;
				end else if (ev.dup_count != DUP_TRIGGER) begin
					nxt.window = win_sat({3'b000, w} + 19'd2);
					clr = 1'b1;
				end else begin
					nxt.threshold = ca_thr;
					nxt.window = win_sat({3'b000, half_plus3(ca_thr)});
					nxt.phase = PH_FR;
				end
			end
			PH_FR: begin
				// Timeout wins over the duplicate checks.
				if (ev.timeout_event) begin
					nxt.threshold = ca_thr;
					nxt.window = WIN_RESET;
					clr = 1'b1;
					nxt.phase = PH_SS;
				end else if (!ev.dup_event) begin
					nxt.window = win_sat({4'b0000, t[WIN_W-1:1]});
					clr = 1'b1;
					nxt.phase = PH_CA;
				end else begin
					nxt.window = win_sat({3'b000, w} + 19'd1);
				end
			end
			default: begin
				// Unused phase code: hold everything.
				nxt = cur;
				clr = 1'b0;
			end
		endcase
	end

endmodule

>>> tb/sv/tb_congestion_window_controller_core.sv
module tb_congestion_window_controller_core;
	import cwc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PER_PHASE = 390;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [WIN_W-1:0] window;
		logic [WIN_W-1:0] threshold;
		phase_t           phase;
		logic             clear_dup;
	} cwnd_result_t;

	typedef struct packed {
		logic             tmo;
		logic             dup;
		logic [CNT_W-1:0] cnt;
		bit               typed;
		cwnd_result_t     want;
	} cwnd_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             timeout_event;
	logic             dup_event;
	logic [CNT_W-1:0] dup_count;
	logic             out_valid;
	logic             out_stall;
	logic [WIN_W-1:0] window;
	logic [WIN_W-1:0] threshold;
	logic [1:0]       phase;
	logic             clear_dup;

	// predicted controller state
	phase_t           cwnd_phase = PH_SS;
	logic [WIN_W-1:0] cwnd_size = WIN_RESET;
	logic [WIN_W-1:0] ssthresh = THRESH_RESET;

	cwnd_result_t pending_cwnd [$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           sender_idle_pct = 0;
	int           recv_stall_pct = 0;
	bit           hold_armed = 1'b0;
	int           hold_left = 0;

	// tmo, dup, cnt, typed, {window, threshold, phase, clear_dup}
	cwnd_row_t directed_rows [0:23] = '{
		{1'b0, 1'b0, 4'd0,  1'b1, 16'd8, 16'd2000, PH_SS, 1'b1},
		{1'b1, 1'b1, 4'd15, 1'b1, 16'd1, 16'd7,    PH_SS, 1'b1},
		{1'b0, 1'b1, 4'd15, 1'b1, 16'd8, 16'd7,    PH_CA, 1'b1},
		{1'b0, 1'b0, 4'd3,  1'b1, 16'd6, 16'd7,    PH_FR, 1'b0},
		{1'b0, 1'b1, 4'd0,  1'b1, 16'd7, 16'd7,    PH_FR, 1'b0},
		{1'b0, 1'b1, 4'd15, 1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b0, 4'd3,  1'b1, 16'd3, 16'd7,    PH_CA, 1'b1},
		{1'b1, 1'b0, 4'd3,  1'b1, 16'd1, 16'd4,    PH_SS, 1'b1},
		{1'b0, 1'b0, 4'd3,  1'b1, 16'd6, 16'd5,    PH_FR, 1'b0},
		{1'b1, 1'b1, 4'd3,  1'b1, 16'd1, 16'd6,    PH_SS, 1'b1},
		// duplicate trigger wins over a timeout in slow start
		{1'b1, 1'b0, 4'd3,  1'b1, 16'd6, 16'd6,    PH_FR, 1'b0},
		{1'b0, 1'b0, 4'd10, 1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b1, 4'd5,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b1, 1'b1, 4'd0,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b0, 4'd1,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b1, 4'd2,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b0, 4'd4,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b1, 4'd8,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b1, 1'b0, 4'd3,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b0, 4'd15, 1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b1, 4'd0,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b0, 4'd3,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b0, 1'b1, 4'd3,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0},
		{1'b1, 1'b0, 4'd0,  1'b0, 16'd0, 16'd0,    PH_SS, 1'b0}
	};

	congestion_window_controller_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.timeout_event (timeout_event),
		.dup_event     (dup_event),
		.dup_count     (dup_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.window        (window),
		.threshold     (threshold),
		.phase         (phase),
		.clear_dup     (clear_dup)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [WIN_W-1:0] cap_window(input int unsigned v);
		return (v > WIN_MAX) ? WIN_MAX : v[WIN_W-1:0];
	endfunction

	function automatic cwnd_result_t advance_cwnd(input logic tmo, input logic dup,
			input logic [CNT_W-1:0] cnt);
		int unsigned  w;
		int unsigned  t;
		int unsigned  nt;
		logic [WIN_W-1:0] nw;
		phase_t       np;
		logic         clr;
		cwnd_result_t r;
		w = cwnd_size;
		t = ssthresh;
		nw = cwnd_size;
		nt = t;
		np = cwnd_phase;
		clr = 1'b0;
		case (cwnd_phase)
			PH_SS: begin
				if (cnt == DUP_TRIGGER) begin
					nt = t / 2 + 3;
					nw = cap_window(w + 5);
					np = PH_FR;
				end else if (!tmo) begin
					nw = cap_window(w * 8);
					clr = 1'b1;
					if (nw >= t)
						np = PH_CA;
				end else begin
					nt = w / 2 + 3;
					nw = WIN_RESET;
					clr = 1'b1;
				end
			end
			PH_CA: begin
				if (tmo) begin
					nt = w / 2 + 3;
					nw = WIN_RESET;
					clr = 1'b1;
					np = PH_SS;
				end else if (cnt != DUP_TRIGGER) begin
					nw = cap_window(w + 2);
					clr = 1'b1;
				end else begin
					nt = w / 2 + 3;
					nw = cap_window(nt / 2 + 3);
					np = PH_FR;
				end
			end
			PH_FR: begin
				// timeout takes priority in fast recovery
				if (tmo) begin
					nt = w / 2 + 3;
					nw = WIN_RESET;
					clr = 1'b1;
					np = PH_SS;
				end else if (!dup) begin
					nw = cap_window(t / 2);
					clr = 1'b1;
					np = PH_CA;
				end else begin
					nw = cap_window(w + 1);
				end
			end
			default: ;
		endcase
		cwnd_size = nw;
		ssthresh = nt[WIN_W-1:0];
		cwnd_phase = np;
		r.window = cwnd_size;
		r.threshold = ssthresh;
		r.phase = cwnd_phase;
		r.clear_dup = clr;
		return r;
	endfunction

	// Enter and leave at a falling edge; predict at the accepting rising edge.
	task automatic drive_event(input logic tmo, input logic dup, input logic [CNT_W-1:0] cnt,
			input bit typed, input cwnd_result_t want);
		cwnd_result_t got;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		timeout_event <= tmo;
		dup_event <= dup;
		dup_count <= cnt;
		do
			@(posedge clk);
		while (in_stall);
		got = advance_cwnd(tmo, dup, cnt);
		pending_cwnd.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// receiver: random stall, plus one long hold when armed
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cwnd_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cwnd.size() == 0) begin
				$error("result transfer with nothing expected: window %0d threshold %0d",
					window, threshold);
				mismatch_count++;
			end else begin
				exp_r = pending_cwnd.pop_front();
				if (window !== exp_r.window) begin
					$error("window: expected %0d, got %0d", exp_r.window, window);
					mismatch_count++;
				end
				if (threshold !== exp_r.threshold) begin
					$error("threshold: expected %0d, got %0d", exp_r.threshold, threshold);
					mismatch_count++;
				end
				if (phase !== exp_r.phase) begin
					$error("phase: expected %0d, got %0d", exp_r.phase, phase);
					mismatch_count++;
				end
				if (clear_dup !== exp_r.clear_dup) begin
					$error("clear_dup: expected %0d, got %0d", exp_r.clear_dup, clear_dup);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic             tmo;
		logic             dup;
		logic [CNT_W-1:0] cnt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		timeout_event = 1'b0;
		dup_event = 1'b0;
		dup_count = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++)
			drive_event(directed_rows[i].tmo, directed_rows[i].dup, directed_rows[i].cnt,
				directed_rows[i].typed, directed_rows[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
					hold_armed = 1'b1;
				end
				1: begin
					sender_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					sender_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				tmo = ($urandom_range(99) < 8);
				dup = 1'($urandom_range(1));
				cnt = ($urandom_range(99) < 25) ? DUP_TRIGGER : CNT_W'($urandom_range(15));
				if ($urandom_range(99) < 10)
					{tmo, dup, cnt} = (CNT_W + 2)'($urandom);
				drive_event(tmo, dup, cnt, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_cwnd.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
